// ===== rtl/pfd_pkg.sv =====
package pfd_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int TAG_W = 16;
	localparam int TS_W  = 64;
	localparam int NON_B_LIMIT = 2;

	localparam int FL_B    = 0;
	localparam int FL_SKIP = 1;
	localparam int FL_PTS  = 2;
	localparam int FL_DUR  = 3;

	typedef enum logic {
		OP_PACKET = 1'b0,
		OP_FLUSH  = 1'b1
	} op_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  dts;
		logic [TS_W-1:0]  pts;
		logic [TS_W-1:0]  dur;
		logic [3:0]       flags;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic load;
		logic set_dur;
		logic set_pts;
	} cell_ctl_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUR,
		ST_DRAIN,
		ST_SCAN,
		ST_TIME,
		ST_POP
	} state_t;

endpackage

// ===== rtl/pfd_cell.sv =====
module pfd_cell
	import pfd_pkg::*;
(
	input  logic            clk,
	input  cell_ctl_t       ctl,
	input  entry_t          next_ent,
	input  entry_t          new_ent,
	input  logic [TS_W-1:0] dur_bus,
	input  logic [TS_W-1:0] pts_bus,
	output entry_t          ent
);

	entry_t ent_q;

	// Shift and load never coincide; time and duration updates go to one cell at a time.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ent_q <= next_ent;
		end else if (ctl.load) begin
			ent_q <= new_ent;
		end else begin
			if (ctl.set_dur) begin
				ent_q.dur <= dur_bus;
				ent_q.flags[FL_DUR] <= 1'b1;
			end
			if (ctl.set_pts) begin
				ent_q.pts <= pts_bus;
				ent_q.flags[FL_PTS] <= 1'b1;
			end
		end
	end

	assign ent = ent_q;

endmodule

// ===== rtl/pts_from_dts_reorder.sv =====
// PTS recovery for a video stream that carries decode timestamps only.
// Input channel: present a transaction with start high; it is taken on a
// rising edge where start is high and busy is low. op selects a packet or
// an end-of-stream flush. Packets wait in a chain of 32 cells, head first;
// popping the head shifts every cell one place toward the head.
// Result channel: each result shows on the output ports for one cycle with
// out_valid high; last marks the final result of a transaction. The
// receiver cannot stall, so results are never held back.
// Steps: a skipped packet gives no result. A dropped packet (buffer full)
// gives its single result in the next cycle. A stored packet passes a
// duration step, then per released packet a test, a time step when the
// head itself gets its time, and a shift; each entry of a B run that it
// releases takes a scan step, then a time step on the shared 64-bit adder.
// A scan that finds the B run still open walks the run entry by entry and
// ends the transaction. The last result shows in the cycle in which busy
// drops.
// Reset clears the fill count, the running PTS and its known marker, the
// previous duration and the non-B counter; cell contents are left as they
// are and are never read before being written.
module pts_from_dts_reorder
	import pfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  logic             op,
	input  logic [TAG_W-1:0] tag,
	input  logic [TS_W-1:0]  dts,
	input  logic             dts_valid,
	input  logic [TS_W-1:0]  pts_in,
	input  logic             is_b,
	input  logic             skip_in,
	output logic             out_valid,
	output logic [TAG_W-1:0] out_tag,
	output logic [TS_W-1:0]  pts_out,
	output logic             pts_out_valid,
	output logic [TS_W-1:0]  duration,
	output logic             skipped,
	output logic             dropped_full,
	output logic             last
);

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  pts;
		logic             pv;
		logic [TS_W-1:0]  dur;
		logic             sk;
		logic             dr;
	} result_t;

	state_t state_q, state_d;
	logic [CNT_W-1:0] fill_q;
	logic [TS_W-1:0]  run_q;
	logic             known_q;
	logic [TS_W-1:0]  prevdur_q;
	logic [1:0]       nb_q;
	logic             eof_q;
	logic             pend_q;
	result_t          pend_res_q;
	result_t          out_q;
	logic             out_valid_q;
	logic             last_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] i_q;

	entry_t    ent [DEPTH];
	cell_ctl_t ctl [DEPTH];
	entry_t    new_ent;
	logic [TS_W-1:0] dur_bus;
	logic [TS_W-1:0] pts_bus;
	logic [TS_W-1:0] run_next;

	logic accept;
	logic full;
	logic [IDX_W-1:0] idx_last;
	logic [IDX_W-1:0] idx_prev;
	logic [IDX_W-1:0] tsel;
	logic [IDX_W-1:0] jsel;
	logic [TS_W-1:0]  base;
	logic             scan_b;
	logic             give;

	// Drain decisions, decoded per state.
	logic not_ready;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign full     = (fill_q >= CNT_W'(DEPTH));
	assign idx_last = IDX_W'(fill_q - CNT_W'(1));
	assign idx_prev = IDX_W'(fill_q - CNT_W'(2));
	assign tsel     = (i_q == j_q) ? '0 : i_q[IDX_W-1:0];
	assign jsel     = j_q[IDX_W-1:0];
	assign scan_b   = (j_q < fill_q) && ent[jsel].flags[FL_B];
	assign give     = (i_q == j_q) || !ent[tsel].flags[FL_SKIP];

	// Time base: the first timed packet seeds the running counter with its DTS.
	assign base     = known_q ? run_q : ent[tsel].dts;
	assign run_next = base + (ent[tsel].flags[FL_DUR] ? ent[tsel].dur : '0);

	always_comb begin
		new_ent = '0;
		new_ent.tag = tag;
		new_ent.dts = dts_valid ? dts : pts_in;
		if (is_b) begin
			new_ent.flags[FL_B] = 1'b1;
			new_ent.flags[FL_SKIP] = (nb_q < 2'(NON_B_LIMIT));
		end
	end

	always_comb begin
		dur_bus = (state_q == ST_DUR) ? (ent[idx_last].dts - ent[idx_prev].dts) : prevdur_q;
		pts_bus = base;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op == OP_FLUSH) begin
						state_d = ST_DRAIN;
					end else if (!skip_in && !full) begin
						state_d = ST_DUR;
					end
				end
			end
			ST_DUR: state_d = ST_DRAIN;
			ST_DRAIN: begin
				if (fill_q == '0) begin
					state_d = ST_IDLE;
				end else if (ent[0].flags[FL_SKIP] || ent[0].flags[FL_PTS] ||
						ent[0].flags[FL_B]) begin
					state_d = ST_POP;
				end else if (fill_q == CNT_W'(1)) begin
					state_d = eof_q ? ST_TIME : ST_IDLE;
				end else if (!ent[1].flags[FL_B]) begin
					state_d = ST_TIME;
				end else begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_b) begin
					state_d = ST_SCAN;
				end else if (j_q >= fill_q && !eof_q) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_TIME;
				end
			end
			ST_TIME: state_d = (i_q == j_q) ? ST_POP : ST_TIME;
			ST_POP:  state_d = ST_DRAIN;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer toward the cells and the drain logic.
	always_comb begin
		not_ready = 1'b0;
		for (int k = 0; k < DEPTH; k++) begin
			ctl[k] = '0;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept && op == OP_PACKET && !skip_in && !full) begin
					ctl[fill_q[IDX_W-1:0]].load = 1'b1;
				end
				if (accept && op == OP_FLUSH && fill_q != '0) begin
					ctl[idx_last].set_dur = 1'b1;
				end
			end
			ST_DUR: begin
				if (fill_q > CNT_W'(1)) begin
					ctl[idx_prev].set_dur = 1'b1;
				end
			end
			ST_DRAIN: not_ready = (state_d == ST_IDLE);
			ST_SCAN:  not_ready = (state_d == ST_IDLE);
			ST_TIME: begin
				if (give) begin
					ctl[tsel].set_pts = 1'b1;
				end
			end
			ST_POP: begin
				for (int k = 0; k < DEPTH; k++) begin
					ctl[k].shift = 1'b1;
				end
			end
			default: not_ready = 1'b0;
		endcase
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		entry_t nxt;
		if (g == DEPTH - 1) begin : g_tail
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = ent[g+1];
		end
		pfd_cell u_cell (
			.clk      (clk),
			.ctl      (ctl[g]),
			.next_ent (nxt),
			.new_ent  (new_ent),
			.dur_bus  (dur_bus),
			.pts_bus  (pts_bus),
			.ent      (ent[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			run_q       <= '0;
			known_q     <= 1'b0;
			prevdur_q   <= '0;
			nb_q        <= '0;
			eof_q       <= 1'b0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
			last_q      <= 1'b0;
			j_q         <= '0;
			i_q         <= '0;
		end else begin
			state_q     <= state_d;
			// Strobe a result on a drop, on a pop behind a pending one, or at the end.
			out_valid_q <= (accept && op == OP_PACKET && !skip_in && full) ||
				(state_q == ST_POP && pend_q) || (not_ready && pend_q);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						eof_q <= (op == OP_FLUSH);
						if (op == OP_PACKET && !skip_in) begin
							if (full) begin
								// Drop and flag: the single result of this transaction.
								// Fields: tag, pts, pv, dur, sk, dr.
								out_q  <= {tag, {TS_W{1'b0}}, 1'b0, {TS_W{1'b0}}, 1'b0, 1'b1};
								last_q <= 1'b1;
							end else begin
								fill_q <= fill_q + CNT_W'(1);
								if (!is_b && nb_q < 2'(NON_B_LIMIT)) begin
									nb_q <= nb_q + 2'd1;
								end
							end
						end
					end
				end
				ST_DUR: begin
					if (fill_q > CNT_W'(1)) begin
						prevdur_q <= dur_bus;
					end
				end
				ST_DRAIN: begin
					i_q <= CNT_W'(1);
					// Head times alone when there is no B run to walk.
					j_q <= (state_d == ST_TIME) ? CNT_W'(1) : CNT_W'(2);
				end
				ST_SCAN: begin
					if (scan_b) begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_TIME: begin
					if (give) begin
						run_q   <= run_next;
						known_q <= 1'b1;
					end
					if (i_q != j_q) begin
						i_q <= i_q + CNT_W'(1);
					end
				end
				ST_POP: begin
					// Release the previous result now that a successor exists.
					if (pend_q) begin
						out_q  <= pend_res_q;
						last_q <= 1'b0;
					end
					pend_q         <= 1'b1;
					pend_res_q.tag <= ent[0].tag;
					pend_res_q.pv  <= ent[0].flags[FL_PTS];
					pend_res_q.pts <= ent[0].flags[FL_PTS] ? ent[0].pts : '0;
					pend_res_q.dur <= ent[0].flags[FL_DUR] ? ent[0].dur : '0;
					pend_res_q.sk  <= ent[0].flags[FL_SKIP];
					pend_res_q.dr  <= 1'b0;
					fill_q         <= fill_q - CNT_W'(1);
				end
				default: begin
				end
			endcase
			if (not_ready) begin
				if (pend_q) begin
					out_q  <= pend_res_q;
					last_q <= 1'b1;
					pend_q <= 1'b0;
				end
				if (eof_q) begin
					// End of stream: clear all tracking state.
					fill_q    <= '0;
					run_q     <= '0;
					known_q   <= 1'b0;
					prevdur_q <= '0;
					nb_q      <= '0;
					eof_q     <= 1'b0;
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_tag       = out_q.tag;
	assign pts_out       = out_q.pts;
	assign pts_out_valid = out_q.pv;
	assign duration      = out_q.dur;
	assign skipped       = out_q.sk;
	assign dropped_full  = out_q.dr;
	assign last          = last_q;

endmodule

// ===== rtl/pfd_checker.sv =====
module pfd_checker
	import pfd_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             start,
	input logic             busy,
	input logic             op,
	input logic             skip_in,
	input logic             out_valid,
	input logic [TS_W-1:0]  pts_out,
	input logic             pts_out_valid,
	input logic             dropped_full,
	input logic             last
);

	a_drop_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_full |-> last)
		else $error("dropped transaction result without last");

	a_drop_no_pts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && dropped_full |-> !pts_out_valid)
		else $error("dropped result carries a timestamp");

	a_pts_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pts_out_valid |-> pts_out == '0)
		else $error("untimed result with nonzero pts");

	a_skip_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && op == OP_PACKET && skip_in |=> !out_valid && !busy)
		else $error("skipped packet produced activity");

endmodule

bind pts_from_dts_reorder pfd_checker u_pfd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.op            (op),
	.skip_in       (skip_in),
	.out_valid     (out_valid),
	.pts_out       (pts_out),
	.pts_out_valid (pts_out_valid),
	.dropped_full  (dropped_full),
	.last          (last)
);

// ===== sim/pts_from_dts_reorder_chk.sv =====
`timescale 1ns / 100ps

module pts_from_dts_reorder_chk
	import pfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             op,
	input  logic [TAG_W-1:0] tag,
	input  logic [TS_W-1:0]  dts,
	input  logic             dts_valid,
	input  logic [TS_W-1:0]  pts_in,
	input  logic             is_b,
	input  logic             skip_in,
	input  logic             out_valid,
	input  logic [TAG_W-1:0] out_tag,
	input  logic [TS_W-1:0]  pts_out,
	input  logic             pts_out_valid,
	input  logic [TS_W-1:0]  duration,
	input  logic             skipped,
	input  logic             dropped_full,
	input  logic             last,
	output int               fail_count,
	output int               pending_count
);

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  pts;
		logic             pv;
		logic [TS_W-1:0]  dur;
		logic             sk;
		logic             dr;
		logic             lst;
	} pkt_result_t;

	entry_t      slots[DEPTH];
	int          fill;
	logic [63:0] run_pts;
	logic        run_known;
	logic [63:0] prev_dur;
	int          non_b;
	pkt_result_t expected_q[$];

	assign pending_count = expected_q.size();

	function automatic void stamp(int i);
		if (!run_known) begin
			run_pts   = slots[i].dts;
			run_known = 1'b1;
		end
		slots[i].pts = run_pts;
		slots[i].flags[FL_PTS] = 1'b1;
		if (slots[i].flags[FL_DUR])
			run_pts += slots[i].dur;
	endfunction

	function automatic bit head_can_leave(bit eos);
		int last_b;
		if (fill == 0)
			return 0;
		if (slots[0].flags[FL_SKIP] || slots[0].flags[FL_PTS] || slots[0].flags[FL_B])
			return 1;
		if (fill == 1) begin
			if (!eos)
				return 0;
			stamp(0);
			return 1;
		end
		if (!slots[1].flags[FL_B]) begin
			stamp(0);
			return 1;
		end
		last_b = 2;
		while (last_b < fill && slots[last_b].flags[FL_B])
			last_b++;
		if (last_b >= fill && !eos)
			return 0;
		for (int i = 1; i < last_b; i++)
			if (!slots[i].flags[FL_SKIP])
				stamp(i);
		stamp(0);
		return 1;
	endfunction

	function automatic void release_heads(bit eos);
		int n;
		pkt_result_t r;
		n = 0;
		while (n < 32 && head_can_leave(eos)) begin
			r.tag = slots[0].tag;
			r.pv  = slots[0].flags[FL_PTS];
			r.pts = r.pv ? slots[0].pts : '0;
			r.dur = slots[0].flags[FL_DUR] ? slots[0].dur : '0;
			r.sk  = slots[0].flags[FL_SKIP];
			r.dr  = 1'b0;
			r.lst = 1'b0;
			expected_q.push_back(r);
			for (int i = 0; i < fill - 1; i++)
				slots[i] = slots[i + 1];
			fill--;
			n++;
		end
		if (n > 0)
			expected_q[$].lst = 1'b1;
	endfunction

	function automatic void clear_stream();
		fill      = 0;
		run_pts   = '0;
		run_known = 1'b0;
		prev_dur  = '0;
		non_b     = 0;
	endfunction

	function automatic void predict_transaction();
		entry_t e;
		pkt_result_t r;
		if (op == OP_FLUSH) begin
			if (fill > 0) begin
				slots[fill - 1].dur = prev_dur;
				slots[fill - 1].flags[FL_DUR] = 1'b1;
			end
			release_heads(1'b1);
			clear_stream();
			return;
		end
		if (skip_in)
			return;
		if (fill >= DEPTH) begin
			r = '0;
			r.tag = tag;
			r.dr  = 1'b1;
			r.lst = 1'b1;
			expected_q.push_back(r);
			return;
		end
		e = '0;
		if (is_b) begin
			e.flags[FL_B] = 1'b1;
			if (non_b < NON_B_LIMIT)
				e.flags[FL_SKIP] = 1'b1;
		end else if (non_b < NON_B_LIMIT) begin
			non_b++;
		end
		e.tag = tag;
		e.dts = dts_valid ? dts : pts_in;
		slots[fill] = e;
		if (fill > 0) begin
			slots[fill - 1].dur = e.dts - slots[fill - 1].dts;
			slots[fill - 1].flags[FL_DUR] = 1'b1;
			prev_dur = slots[fill - 1].dur;
		end
		fill++;
		release_heads(1'b0);
	endfunction

	always @(posedge clk) begin
		pkt_result_t want;
		pkt_result_t got;
		if (!arst_n) begin
			fail_count = 0;
			clear_stream();
		end else begin
			// results of earlier transactions are checked before the new one is predicted
			if (out_valid) begin
				got = {out_tag, pts_out, pts_out_valid, duration, skipped, dropped_full, last};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, actual %h", $time, got);
					fail_count++;
				end else begin
					want = expected_q.pop_front();
					if (got.tag !== want.tag) begin
						$display("%0t: out_tag expected %h actual %h", $time, want.tag, got.tag);
						fail_count++;
					end
					if (got.pts !== want.pts) begin
						$display("%0t: pts_out expected %h actual %h", $time, want.pts, got.pts);
						fail_count++;
					end
					if (got.pv !== want.pv) begin
						$display("%0t: pts_out_valid expected %b actual %b", $time, want.pv, got.pv);
						fail_count++;
					end
					if (got.dur !== want.dur) begin
						$display("%0t: duration expected %h actual %h", $time, want.dur, got.dur);
						fail_count++;
					end
					if (got.sk !== want.sk) begin
						$display("%0t: skipped expected %b actual %b", $time, want.sk, got.sk);
						fail_count++;
					end
					if (got.dr !== want.dr) begin
						$display("%0t: dropped_full expected %b actual %b", $time, want.dr, got.dr);
						fail_count++;
					end
					if (got.lst !== want.lst) begin
						$display("%0t: last expected %b actual %b", $time, want.lst, got.lst);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				predict_transaction();
		end
	end

endmodule

// ===== sim/pts_from_dts_reorder_tb.sv =====
`timescale 1ns / 100ps

module pts_from_dts_reorder_tb;
	import pfd_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             op;
	logic [TAG_W-1:0] tag;
	logic [TS_W-1:0]  dts;
	logic             dts_valid;
	logic [TS_W-1:0]  pts_in;
	logic             is_b;
	logic             skip_in;
	logic             out_valid;
	logic [TAG_W-1:0] out_tag;
	logic [TS_W-1:0]  pts_out;
	logic             pts_out_valid;
	logic [TS_W-1:0]  duration;
	logic             skipped;
	logic             dropped_full;
	logic             last;
	int               fail_count;
	int               pending_count;

	// sender gap rate in percent for the current phase
	int               gap_pct;
	// decode clock of the synthetic stream
	logic [63:0]      stream_dts;

	pts_from_dts_reorder uut (.*);
	pts_from_dts_reorder_chk checker_i (.*);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// hard stop for a hung block
	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Present one transaction and hold it until the block takes it.
	task automatic send(logic o, logic [15:0] t, logic [63:0] d, logic dv,
			logic [63:0] p, logic b, logic s);
		while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		op        <= o;
		tag       <= t;
		dts       <= d;
		dts_valid <= dv;
		pts_in    <= p;
		is_b      <= b;
		skip_in   <= s;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Send a packet timed from the running stream clock.
	task automatic send_frame(logic b);
		logic [63:0] step;
		logic        dv;
		step = $urandom_range(4) == 0 ? {$urandom, $urandom} : 64'($urandom_range(3000, 1));
		stream_dts += step;
		dv = $urandom_range(5) != 0;
		if (dv)
			send(OP_PACKET, 16'($urandom), stream_dts, 1'b1, {$urandom, $urandom}, b,
				$urandom_range(19) == 0);
		else
			send(OP_PACKET, 16'($urandom), {$urandom, $urandom}, 1'b0, stream_dts, b,
				$urandom_range(19) == 0);
	endtask

	// Emit an I/P frame followed by a B run of random length.
	task automatic send_group();
		int run_len;
		send_frame(1'b0);
		run_len = $urandom_range(3);
		repeat (run_len)
			send_frame(1'b1);
	endtask

	task automatic flush_stream();
		send(OP_FLUSH, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
			{$urandom, $urandom}, 1'($urandom), 1'($urandom));
		stream_dts = {$urandom, $urandom};
	endtask

	initial begin
		int tick;
		arst_n     = 1'b0;
		start      = 1'b0;
		op         = OP_PACKET;
		tag        = '0;
		dts        = '0;
		dts_valid  = 1'b0;
		pts_in     = '0;
		is_b       = 1'b0;
		skip_in    = 1'b0;
		gap_pct    = 0;
		stream_dts = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty flush, leading B frames, extremes, fill to full and overflow
		send(OP_FLUSH, 16'h0000, '0, 1'b0, '0, 1'b0, 1'b0);
		send(OP_PACKET, 16'hffff, 64'h7fff_ffff_ffff_ffff, 1'b1, '0, 1'b1, 1'b0);
		send(OP_PACKET, 16'h0001, 64'h8000_0000_0000_0000, 1'b1, '1, 1'b0, 1'b0);
		send(OP_PACKET, 16'h0002, '1, 1'b0, 64'h8000_0000_0000_0000, 1'b1, 1'b0);
		send(OP_PACKET, 16'h0003, '0, 1'b1, '0, 1'b0, 1'b1);
		send(OP_PACKET, 16'h0004, 64'd100, 1'b1, '0, 1'b0, 1'b0);
		send(OP_PACKET, 16'h0005, 64'd140, 1'b0, 64'd140, 1'b1, 1'b0);
		send(OP_PACKET, 16'h0006, 64'h7fff_ffff_ffff_ffff, 1'b1, '0, 1'b0, 1'b0);
		send(OP_FLUSH, 16'h0000, '0, 1'b0, '0, 1'b0, 1'b0);
		// open B run fills the buffer: head waits, overflow packets are dropped
		send(OP_PACKET, 16'h0010, 64'd0, 1'b1, '0, 1'b0, 1'b0);
		send(OP_PACKET, 16'h0011, 64'd10, 1'b1, '0, 1'b0, 1'b0);
		for (int i = 0; i < 33; i++)
			send(OP_PACKET, 16'(16'h0020 + i), 64'(20 + 10 * i), 1'b1, '0, 1'b1, 1'b0);
		send(OP_FLUSH, 16'h0000, '0, 1'b0, '0, 1'b0, 1'b0);
		// a lone packet released only by the flush
		send(OP_PACKET, 16'h0100, 64'd5, 1'b1, '0, 1'b0, 1'b0);
		send(OP_FLUSH, 16'h0000, '0, 1'b0, '0, 1'b0, 1'b0);

		// random streams: mostly well-formed GOPs, some raw noise, then a flush
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct = phase == 0 ? 23 : (phase == 1 ? 70 : 0);
			for (int s = 0; s < 6; s++) begin
				stream_dts = {$urandom, $urandom};
				repeat ($urandom_range(12, 4)) begin
					if ($urandom_range(9) == 0)
						send(OP_PACKET, 16'($urandom), {$urandom, $urandom}, 1'($urandom),
							{$urandom, $urandom}, 1'($urandom), 1'($urandom));
					else
						send_group();
				end
				flush_stream();
			end
		end
		start <= 1'b0;

		tick = 0;
		while (pending_count != 0 && tick < 10000) begin
			@(posedge clk);
			tick++;
		end
		repeat (200) @(posedge clk);
		if (fail_count == 0 && pending_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
